### rtl/core/bpd_pkg.sv
package bpd_pkg;

    // Result status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_MISALIGNED = 2'd1;
    localparam logic [1:0] ST_RANGE      = 2'd2;

    // Instruction classes.
    localparam logic [3:0] CLS_OTHER  = 4'd0;
    localparam logic [3:0] CLS_B      = 4'd1;
    localparam logic [3:0] CLS_BL     = 4'd2;
    localparam logic [3:0] CLS_BCOND  = 4'd3;
    localparam logic [3:0] CLS_CBZ    = 4'd4;
    localparam logic [3:0] CLS_CBNZ   = 4'd5;
    localparam logic [3:0] CLS_TBZ    = 4'd6;
    localparam logic [3:0] CLS_TBNZ   = 4'd7;
    localparam logic [3:0] CLS_BR     = 4'd8;
    localparam logic [3:0] CLS_BLR    = 4'd9;
    localparam logic [3:0] CLS_RET    = 4'd10;
    localparam logic [3:0] CLS_PCDATA = 4'd11;

    // PC-relative data kinds.
    localparam logic [1:0] PDK_NONE = 2'd0;
    localparam logic [1:0] PDK_ADR  = 2'd1;
    localparam logic [1:0] PDK_ADRP = 2'd2;
    localparam logic [1:0] PDK_LDR  = 2'd3;

    // Control flow kinds.
    localparam logic [2:0] FLOW_SEQ      = 3'd0;
    localparam logic [2:0] FLOW_DIRECT   = 3'd1;
    localparam logic [2:0] FLOW_CALL     = 3'd2;
    localparam logic [2:0] FLOW_COND     = 3'd3;
    localparam logic [2:0] FLOW_INDIRECT = 3'd4;
    localparam logic [2:0] FLOW_ICALL    = 3'd5;
    localparam logic [2:0] FLOW_RETURN   = 3'd6;

    localparam logic [3:0] COND_ALWAYS = 4'd14;

    // Encoding masks and match patterns.
    localparam logic [31:0] MASK_BCOND  = 32'hff000010;
    localparam logic [31:0] PAT_BCOND   = 32'h54000000;
    localparam logic [31:0] MASK_B      = 32'hfc000000;
    localparam logic [31:0] PAT_B       = 32'h14000000;
    localparam logic [31:0] PAT_BL      = 32'h94000000;
    localparam logic [31:0] MASK_CMPBR  = 32'h7e000000;
    localparam logic [31:0] PAT_CB      = 32'h34000000;
    localparam logic [31:0] PAT_TB      = 32'h36000000;
    localparam logic [31:0] MASK_BREG   = 32'hfffffc1f;
    localparam logic [31:0] PAT_BR      = 32'hd61f0000;
    localparam logic [31:0] PAT_BLR     = 32'hd63f0000;
    localparam logic [31:0] PAT_RET     = 32'hd65f0000;
    localparam logic [31:0] MASK_ADR    = 32'h1f000000;
    localparam logic [31:0] PAT_ADR     = 32'h10000000;
    localparam logic [31:0] MASK_LDRLIT = 32'h3b000000;
    localparam logic [31:0] PAT_LDRLIT  = 32'h18000000;

    // Which immediate field forms the PC-relative offset.
    typedef enum logic [2:0] {
        IMM_NONE,
        IMM_26,
        IMM_19,
        IMM_14,
        IMM_21,
        IMM_21_PAGE
    } t_imm_kind;

    typedef struct packed {
        logic [3:0] insn_class;
        logic [1:0] pc_data_kind;
        logic [2:0] flow_kind;
        logic       falls_through;
        t_imm_kind  imm_kind;
        logic [3:0] condition_code;
        logic [4:0] target_register;
        logic       register_valid;
    } t_decode;

endpackage

### rtl/core/aarch64_branch_predecoder_unit.sv
// AArch64 branch predecoder.
// The input channel carries one word per transfer: an instruction encoding
// and the address it was fetched from. The output channel carries one word
// per transfer: the status, the instruction class and PC-relative data kind,
// the flow kind, the fall-through flag, the computed target or data address
// with its valid flag, the condition code and the branch register.
// Both channels use valid and ready; a word moves when both are high.
// The accepting edge loads the input register; from there the word passes
// through decode and the 65-bit target adder into the result register,
// where it is presented. Throughput is one word per cycle while the receiver
// does not stall; the single 65-bit add and its range check set the cycle time.
// When the receiver stalls, the result register holds its word, the input
// register holds the word behind it, and input ready falls only when both
// are occupied. Ready stays high in the cycle the result is taken, so the
// stream keeps moving without a bubble.
// Synchronous reset empties both registers; no results are presented until
// new words arrive. There is no other state.
module aarch64_branch_predecoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_instruction_address,
    input  logic [31:0] i_instruction_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_insn_class,
    output logic [1:0]  o_pc_data_kind,
    output logic [2:0]  o_flow_kind,
    output logic        o_falls_through,
    output logic        o_address_valid,
    output logic [63:0] o_computed_address,
    output logic [3:0]  o_condition_code,
    output logic [4:0]  o_target_register,
    output logic        o_register_valid
);
    import bpd_pkg::*;

    // Input register.
    logic        r_in_valid;
    logic [63:0] r_addr;
    logic [31:0] r_word;

    // Result register.
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [3:0]  r_insn_class;
    logic [1:0]  r_pc_data_kind;
    logic [2:0]  r_flow_kind;
    logic        r_falls_through;
    logic        r_address_valid;
    logic [63:0] r_computed_address;
    logic [3:0]  r_condition_code;
    logic [4:0]  r_target_register;
    logic        r_register_valid;

    logic [1:0]  n_status;
    logic [3:0]  n_insn_class;
    logic [1:0]  n_pc_data_kind;
    logic [2:0]  n_flow_kind;
    logic        n_falls_through;
    logic        n_address_valid;
    logic [63:0] n_computed_address;
    logic [3:0]  n_condition_code;
    logic [4:0]  n_target_register;
    logic        n_register_valid;

    logic        out_free;
    logic        in_take;
    t_decode     dec;
    logic [63:0] target;
    logic        target_fits;

    // The result register can take a new word when it is empty or its word
    // is leaving in this cycle.
    assign out_free   = ~r_out_valid | i_out_ready;
    assign o_in_ready = ~r_in_valid | out_free;
    assign in_take    = i_in_valid & o_in_ready;

    bpd_decode u_decode (
        .i_word (r_word),
        .o_dec  (dec)
    );

    bpd_target u_target (
        .i_addr     (r_addr),
        .i_word     (r_word),
        .i_imm_kind (dec.imm_kind),
        .o_target   (target),
        .o_fits     (target_fits)
    );

    always_comb begin
        n_status           = ST_OK;
        n_insn_class       = dec.insn_class;
        n_pc_data_kind     = dec.pc_data_kind;
        n_flow_kind        = dec.flow_kind;
        n_falls_through    = dec.falls_through;
        n_address_valid    = 1'b0;
        n_computed_address = 64'd0;
        n_condition_code   = dec.condition_code;
        n_target_register  = dec.target_register;
        n_register_valid   = dec.register_valid;
        if (r_addr[1:0] != 2'b00) begin
            // A misaligned address clears every field and sets the condition to always.
            n_status          = ST_MISALIGNED;
            n_insn_class      = CLS_OTHER;
            n_pc_data_kind    = PDK_NONE;
            n_flow_kind       = FLOW_SEQ;
            n_falls_through   = 1'b0;
            n_condition_code  = COND_ALWAYS;
            n_target_register = 5'd0;
            n_register_valid  = 1'b0;
        end else if (dec.imm_kind != IMM_NONE) begin
            if (target_fits) begin
                n_address_valid    = 1'b1;
                n_computed_address = target;
            end else begin
                n_status = ST_RANGE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_addr <= i_instruction_address;
            r_word <= i_instruction_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid) begin
            r_status           <= n_status;
            r_insn_class       <= n_insn_class;
            r_pc_data_kind     <= n_pc_data_kind;
            r_flow_kind        <= n_flow_kind;
            r_falls_through    <= n_falls_through;
            r_address_valid    <= n_address_valid;
            r_computed_address <= n_computed_address;
            r_condition_code   <= n_condition_code;
            r_target_register  <= n_target_register;
            r_register_valid   <= n_register_valid;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_insn_class       = r_insn_class;
    assign o_pc_data_kind     = r_pc_data_kind;
    assign o_flow_kind        = r_flow_kind;
    assign o_falls_through    = r_falls_through;
    assign o_address_valid    = r_address_valid;
    assign o_computed_address = r_computed_address;
    assign o_condition_code   = r_condition_code;
    assign o_target_register  = r_target_register;
    assign o_register_valid   = r_register_valid;

endmodule

### rtl/core/bpd_decode.sv
module bpd_decode (
    input  logic [31:0]      i_word,
    output bpd_pkg::t_decode o_dec
);
    import bpd_pkg::*;

    logic [1:0] opc;

    assign opc = i_word[31:30];

    always_comb begin
        o_dec                 = '0;
        o_dec.imm_kind        = IMM_NONE;
        o_dec.insn_class      = CLS_OTHER;
        o_dec.pc_data_kind    = PDK_NONE;
        o_dec.flow_kind       = FLOW_SEQ;
        o_dec.falls_through   = 1'b1;
        o_dec.condition_code  = COND_ALWAYS;
        o_dec.target_register = 5'd0;
        o_dec.register_valid  = 1'b0;

        // The order of the tests sets the priority between overlapping encodings.
        if ((i_word & MASK_BCOND) == PAT_BCOND) begin
            o_dec.insn_class     = CLS_BCOND;
            o_dec.flow_kind      = FLOW_COND;
            o_dec.condition_code = i_word[3:0];
            o_dec.imm_kind       = IMM_19;
        end else if ((i_word & MASK_B) == PAT_B) begin
            o_dec.insn_class    = CLS_B;
            o_dec.flow_kind     = FLOW_DIRECT;
            o_dec.falls_through = 1'b0;
            o_dec.imm_kind      = IMM_26;
        end else if ((i_word & MASK_B) == PAT_BL) begin
            o_dec.insn_class = CLS_BL;
            o_dec.flow_kind  = FLOW_CALL;
            o_dec.imm_kind   = IMM_26;
        end else if ((i_word & MASK_BREG) == PAT_BR) begin
            o_dec.insn_class      = CLS_BR;
            o_dec.flow_kind       = FLOW_INDIRECT;
            o_dec.falls_through   = 1'b0;
            o_dec.target_register = i_word[9:5];
            o_dec.register_valid  = 1'b1;
        end else if ((i_word & MASK_BREG) == PAT_BLR) begin
            o_dec.insn_class      = CLS_BLR;
            o_dec.flow_kind       = FLOW_ICALL;
            o_dec.target_register = i_word[9:5];
            o_dec.register_valid  = 1'b1;
        end else if ((i_word & MASK_BREG) == PAT_RET) begin
            o_dec.insn_class      = CLS_RET;
            o_dec.flow_kind       = FLOW_RETURN;
            o_dec.falls_through   = 1'b0;
            o_dec.target_register = i_word[9:5];
            o_dec.register_valid  = 1'b1;
        end else if ((i_word & MASK_CMPBR) == PAT_CB) begin
            o_dec.insn_class = i_word[24] ? CLS_CBNZ : CLS_CBZ;
            o_dec.flow_kind  = FLOW_COND;
            o_dec.imm_kind   = IMM_19;
        end else if ((i_word & MASK_CMPBR) == PAT_TB) begin
            o_dec.insn_class = i_word[24] ? CLS_TBNZ : CLS_TBZ;
            o_dec.flow_kind  = FLOW_COND;
            o_dec.imm_kind   = IMM_14;
        end else if ((i_word & MASK_ADR) == PAT_ADR) begin
            o_dec.insn_class = CLS_PCDATA;
            if (i_word[31]) begin
                o_dec.pc_data_kind = PDK_ADRP;
                o_dec.imm_kind     = IMM_21_PAGE;
            end else begin
                o_dec.pc_data_kind = PDK_ADR;
                o_dec.imm_kind     = IMM_21;
            end
        end else if (((i_word & MASK_LDRLIT) == PAT_LDRLIT) && (opc != 2'd3)
                     && !((opc == 2'd2) && !i_word[26])) begin
            // LDRSW and the prefetch form are left out.
            o_dec.insn_class   = CLS_PCDATA;
            o_dec.pc_data_kind = PDK_LDR;
            o_dec.imm_kind     = IMM_19;
        end
    end

endmodule

### rtl/core/bpd_target.sv
module bpd_target (
    input  logic [63:0]        i_addr,
    input  logic [31:0]        i_word,
    input  bpd_pkg::t_imm_kind i_imm_kind,
    output logic [63:0]        o_target,
    output logic               o_fits
);
    import bpd_pkg::*;

    logic [20:0] imm21;
    logic [64:0] offset;
    logic [64:0] base;
    logic [64:0] sum;

    assign imm21 = {i_word[23:5], i_word[30:29]};

    always_comb begin
        base = {1'b0, i_addr};
        case (i_imm_kind)
            IMM_26:      offset = {{37{i_word[25]}}, i_word[25:0], 2'b00};
            IMM_19:      offset = {{44{i_word[23]}}, i_word[23:5], 2'b00};
            IMM_14:      offset = {{49{i_word[18]}}, i_word[18:5], 2'b00};
            IMM_21:      offset = {{44{imm21[20]}}, imm21};
            IMM_21_PAGE: begin
                offset = {{32{imm21[20]}}, imm21, 12'h000};
                base   = {1'b0, i_addr[63:12], 12'h000};
            end
            default:     offset = '0;
        endcase
    end

    // In a 65-bit two's complement sum the top bit is set exactly when the
    // true result lies below zero or at or above 2^64.
    assign sum      = base + offset;
    assign o_target = sum[63:0];
    assign o_fits   = ~sum[64];

endmodule
